// File: hdl/tgapsd_pkg.sv
// ----------------------------------------------------------------------------
// tgapsd_pkg
// Shared types and constants of the targa pixel stream decoder.
// ----------------------------------------------------------------------------
package tgapsd_pkg;

    localparam int TOTAL_W = 25;
    localparam int CFG_W   = 25;
    localparam int ADDR_W  = 8;

    typedef enum logic [1:0] {
        FUNC_PAL  = 2'd0,
        FUNC_IMG  = 2'd1,
        FUNC_NEW  = 2'd2,
        FUNC_NONE = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        REG_IMAGE_KIND    = 3'd0,
        REG_PIXEL_BYTES   = 3'd1,
        REG_ALPHA_USED    = 3'd2,
        REG_RLE_ON        = 3'd3,
        REG_PIXEL_TOTAL   = 3'd4,
        REG_PALETTE_BITS  = 3'd5,
        REG_PALETTE_FIRST = 3'd6,
        REG_PALETTE_COUNT = 3'd7
    } t_reg_idx;

    localparam logic [1:0] KIND_PALETTE = 2'd1;
    localparam logic [1:0] KIND_MONO    = 2'd3;

    typedef struct packed {
        logic [1:0]         image_kind;
        logic [2:0]         pixel_bytes;
        logic               alpha_used;
        logic               rle_on;
        logic [TOTAL_W-1:0] pixel_total;
        logic [5:0]         palette_bits;
        logic [15:0]        palette_first;
        logic [15:0]        palette_count;
    } t_cfg;

    // One word from the front to the back: a palette byte write or a pixel.
    typedef struct packed {
        logic              is_wr;
        logic [ADDR_W-1:0] addr;
        logic [1:0]        lane;
        logic [7:0]        wr_byte;
        logic [31:0]       pix;
        logic [2:0]        nbytes;
        logic              err;
        logic [7:0]        run;
        logic              done;
    } t_job;

    typedef struct packed {
        logic [31:0] argb;
        logic [7:0]  run;
        logic        status;
        logic        done;
    } t_res;

    function automatic logic [7:0] widen5(input logic [4:0] c);
        return {c, c[4:2]};
    endfunction

    function automatic logic [23:0] from555(input logic [15:0] w);
        return {widen5(w[14:10]), widen5(w[9:5]), widen5(w[4:0])};
    endfunction

endpackage

// File: hdl/tgapsd_fifo.sv
// ----------------------------------------------------------------------------
// tgapsd_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
module tgapsd_fifo #(
    parameter int  DEPTH  = 4,
    parameter type t_item = logic
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic          wr, rd;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == PW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == PW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(wr) - (PW+1)'(rd);
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(DEPTH))
        else $error("queue count beyond depth");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == (PW+1)'(DEPTH)) |-> (r_wp == r_rp))
        else $error("queue pointers disagree with count");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr && !rd) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count missed a write");

endmodule

// File: hdl/tgapsd_front.sv
// ----------------------------------------------------------------------------
// tgapsd_front
// Byte classifier: palette entry assembly, packet headers, pixel byte
// assembly, pixel counting and index checks. Emits one word per event.
// ----------------------------------------------------------------------------
module tgapsd_front #(
    parameter int PALETTE_DEPTH = 256,
    parameter int MAX_PIXELS    = 16777216
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tgapsd_pkg::t_cfg      i_cfg,
    input  logic                  i_accept,
    input  logic [1:0]            i_func,
    input  logic [7:0]            i_data_byte,
    output logic                  o_job_push,
    output tgapsd_pkg::t_job      o_job
);
    import tgapsd_pkg::*;

    logic [15:0]        r_pal_cnt, n_pal_cnt;
    logic [1:0]         r_pal_phase, n_pal_phase;
    logic [23:0]        r_pix_buf, n_pix_buf;
    logic [1:0]         r_pix_phase, n_pix_phase;
    logic [7:0]         r_pkt_rem, n_pkt_rem;
    logic               r_pkt_run, n_pkt_run;
    logic [TOTAL_W-1:0] r_emitted, n_emitted;
    logic               r_halted, n_halted;

    logic [TOTAL_W-1:0] tot, left, emitted_sum;
    logic [2:0]         ebytes, nbytes;
    logic [3:0]         eb_raw;
    logic [15:0]        pal_idx;
    logic [31:0]        pix;
    logic [7:0]         run;
    logic               idx_err;

    always_comb begin
        tot = (i_cfg.pixel_total > TOTAL_W'(MAX_PIXELS)) ? TOTAL_W'(MAX_PIXELS)
                                                          : i_cfg.pixel_total;
        eb_raw = 4'((7'(i_cfg.palette_bits) + 7'd1) >> 3);
        if (i_cfg.palette_bits == 6'd15 || i_cfg.palette_bits == 6'd16) begin
            ebytes = 3'd2;
        end else if (eb_raw == 4'd0) begin
            ebytes = 3'd1;
        end else if (eb_raw > 4'd4) begin
            ebytes = 3'd4;
        end else begin
            ebytes = eb_raw[2:0];
        end
        if (i_cfg.pixel_bytes == 3'd0) begin
            nbytes = 3'd1;
        end else if (i_cfg.pixel_bytes > 3'd4) begin
            nbytes = 3'd4;
        end else begin
            nbytes = i_cfg.pixel_bytes;
        end
    end

    always_comb begin
        n_pal_cnt   = r_pal_cnt;
        n_pal_phase = r_pal_phase;
        n_pix_buf   = r_pix_buf;
        n_pix_phase = r_pix_phase;
        n_pkt_rem   = r_pkt_rem;
        n_pkt_run   = r_pkt_run;
        n_emitted   = r_emitted;
        n_halted    = r_halted;
        o_job       = '0;
        o_job_push  = 1'b0;
        pal_idx     = r_pal_cnt - i_cfg.palette_first;
        left        = tot - r_emitted;
        pix         = {8'd0, r_pix_buf};
        unique case (r_pix_phase)
            2'd0:    pix[7:0]   = i_data_byte;
            2'd1:    pix[15:8]  = i_data_byte;
            2'd2:    pix[23:16] = i_data_byte;
            default: pix[31:24] = i_data_byte;
        endcase
        idx_err = (nbytes == 3'd1) && (i_cfg.image_kind == KIND_PALETTE) &&
                  ((16'(pix[7:0]) >= i_cfg.palette_count) ||
                   (9'(pix[7:0]) >= 9'(PALETTE_DEPTH)));
        if (r_pkt_run && i_cfg.rle_on) begin
            run = (TOTAL_W'(r_pkt_rem) > left) ? left[7:0] : r_pkt_rem;
        end else begin
            run = 8'd1;
        end
        emitted_sum = r_emitted + TOTAL_W'(run);

        if (i_accept) begin
            priority if (t_func'(i_func) == FUNC_NEW) begin
                n_pal_cnt   = '0;
                n_pal_phase = '0;
                n_pix_buf   = '0;
                n_pix_phase = '0;
                n_pkt_rem   = '0;
                n_pkt_run   = 1'b0;
                n_emitted   = '0;
                n_halted    = 1'b0;
            end else if (t_func'(i_func) == FUNC_NONE || r_halted) begin
                // Nothing to do.
            end else if (t_func'(i_func) == FUNC_PAL) begin
                if (r_pal_cnt != 16'hffff) begin
                    if (r_pal_cnt >= i_cfg.palette_first &&
                        17'(pal_idx) < 17'(PALETTE_DEPTH)) begin
                        o_job_push    = 1'b1;
                        o_job.is_wr   = 1'b1;
                        o_job.addr    = ADDR_W'(pal_idx);
                        o_job.lane    = r_pal_phase;
                        o_job.wr_byte = i_data_byte;
                    end
                    if (3'(r_pal_phase) + 3'd1 >= ebytes) begin
                        n_pal_phase = '0;
                        n_pal_cnt   = r_pal_cnt + 16'd1;
                    end else begin
                        n_pal_phase = r_pal_phase + 2'd1;
                    end
                end
            end else if (r_emitted >= tot) begin
                // Image complete: data bytes are dropped.
            end else if (i_cfg.rle_on && r_pkt_rem == 8'd0) begin
                n_pkt_run = i_data_byte[7];
                n_pkt_rem = {1'b0, i_data_byte[6:0]} + 8'd1;
            end else if (3'(r_pix_phase) + 3'd1 < nbytes) begin
                n_pix_buf   = pix[23:0];
                n_pix_phase = r_pix_phase + 2'd1;
            end else begin
                n_pix_buf    = '0;
                n_pix_phase  = '0;
                o_job_push   = 1'b1;
                o_job.pix    = pix;
                o_job.nbytes = nbytes;
                if (idx_err) begin
                    n_halted  = 1'b1;
                    o_job.err = 1'b1;
                end else begin
                    if (i_cfg.rle_on && r_pkt_run) begin
                        n_pkt_rem = '0;
                    end else if (i_cfg.rle_on) begin
                        n_pkt_rem = r_pkt_rem - 8'd1;
                    end
                    n_emitted  = emitted_sum;
                    o_job.run  = run;
                    o_job.done = (emitted_sum >= tot);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_cnt   <= '0;
            r_pal_phase <= '0;
            r_pix_buf   <= '0;
            r_pix_phase <= '0;
            r_pkt_rem   <= '0;
            r_pkt_run   <= 1'b0;
            r_emitted   <= '0;
            r_halted    <= 1'b0;
        end else begin
            r_pal_cnt   <= n_pal_cnt;
            r_pal_phase <= n_pal_phase;
            r_pix_buf   <= n_pix_buf;
            r_pix_phase <= n_pix_phase;
            r_pkt_rem   <= n_pkt_rem;
            r_pkt_run   <= n_pkt_run;
            r_emitted   <= n_emitted;
            r_halted    <= n_halted;
        end
    end

    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_job_push && o_job.err) |=> r_halted)
        else $error("index error did not halt the decoder");
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> !o_job_push)
        else $error("word issued while halted");
    a_pkt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pkt_rem <= 8'd128)
        else $error("packet count out of range");
    a_buf_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pix_phase == 2'd0) |-> (r_pix_buf == '0))
        else $error("pixel byte buffer not clear at pixel start");

endmodule

// File: hdl/tgapsd_back.sv
// ----------------------------------------------------------------------------
// tgapsd_back
// Executes words: palette byte writes, palette lookup and pixel format
// conversion to ARGB. Two stages: memory access, then conversion.
// ----------------------------------------------------------------------------
module tgapsd_back #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tgapsd_pkg::t_cfg  i_cfg,
    input  logic              i_job_empty,
    input  tgapsd_pkg::t_job  i_job,
    output logic              o_job_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output tgapsd_pkg::t_res  o_res
);
    import tgapsd_pkg::*;

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic [3:0][7:0] r_pal [PALETTE_DEPTH];
    logic [31:0]     r_rdata;
    t_job            r_job;
    logic            r_valid;
    logic            fire;

    logic [7:0]  a;
    logic [23:0] rgb;
    logic [15:0] w;
    logic [7:0]  p0, p1, p3;

    assign o_res_push = r_valid;
    assign fire       = !i_job_empty && (!r_valid || !i_res_full);
    assign o_job_pop  = fire;

    // Lane zero of an entry clears the upper bytes, as a fresh entry starts.
    always_ff @(posedge i_clk) begin
        if (fire && i_job.is_wr) begin
            unique case (i_job.lane)
                2'd0: r_pal[i_job.addr[AW-1:0]] <= {24'd0, i_job.wr_byte};
                2'd1: r_pal[i_job.addr[AW-1:0]][1] <= i_job.wr_byte;
                2'd2: r_pal[i_job.addr[AW-1:0]][2] <= i_job.wr_byte;
                default: r_pal[i_job.addr[AW-1:0]][3] <= i_job.wr_byte;
            endcase
        end
        if (fire && !i_job.is_wr) begin
            r_rdata <= r_pal[i_job.pix[AW-1:0]];
            r_job   <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (fire) begin
            r_valid <= !i_job.is_wr;
        end else if (!i_res_full) begin
            r_valid <= 1'b0;
        end
    end

    always_comb begin
        p0  = r_job.pix[7:0];
        p1  = r_job.pix[15:8];
        p3  = r_job.pix[31:24];
        w   = r_job.pix[15:0];
        a   = 8'hff;
        rgb = r_job.pix[23:0];
        if (r_job.nbytes == 3'd4 || r_job.nbytes == 3'd3) begin
            if (r_job.nbytes == 3'd4 && i_cfg.alpha_used) begin
                a = p3;
            end
        end else if (r_job.nbytes == 3'd2) begin
            if (i_cfg.image_kind == KIND_MONO) begin
                rgb = {p0, p0, p0};
                if (i_cfg.alpha_used) begin
                    a = p1;
                end
            end else begin
                rgb = from555(w);
                if (i_cfg.alpha_used && !w[15]) begin
                    a = 8'd0;
                end
            end
        end else if (i_cfg.image_kind == KIND_PALETTE) begin
            if (i_cfg.palette_bits == 6'd24) begin
                rgb = r_rdata[23:0];
            end else if (i_cfg.palette_bits == 6'd32) begin
                rgb = r_rdata[23:0];
                if (i_cfg.alpha_used) begin
                    a = r_rdata[31:24];
                end
            end else if (i_cfg.palette_bits == 6'd15 || i_cfg.palette_bits == 6'd16) begin
                rgb = from555(r_rdata[15:0]);
            end else begin
                rgb = 24'hffffff;
            end
        end else begin
            rgb = {p0, p0, p0};
        end

        o_res.run    = r_job.run;
        o_res.status = r_job.err;
        o_res.done   = r_job.done;
        if (r_job.err || a == 8'd0) begin
            o_res.argb = '0;
        end else begin
            o_res.argb = {a, rgb};
        end
    end

    a_no_wr_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !r_job.is_wr)
        else $error("palette write reached the result stage");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_res_full) |=> (r_valid && $stable(r_job)))
        else $error("stalled pixel was lost");
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_job.err) |-> (o_res.run == 8'd0 && !o_res.done))
        else $error("error result carries pixel data");

endmodule

// File: hdl/tga_pixel_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder_top
// Targa image body decoder: palette load, raw and run-length pixel decode.
// ----------------------------------------------------------------------------
// Path: a pixel's result reaches the output ports from the edge that accepts its
//   last byte via the word queue, the palette read stage and the result queue.
// Throughput: one byte per cycle while not full; the back stage, while the result
//   queue does not stall it, executes one word per cycle, either a palette byte write or a pixel with its palette read.
// Reset: synchronous active low; clears counters, queues and the halt flag,
//   loads register defaults; palette contents are undefined until written.
module tga_pixel_stream_decoder_top #(
    parameter int PALETTE_DEPTH = 256,
    parameter int MAX_PIXELS    = 16777216
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_argb,
    output logic [7:0]  o_run_length,
    output logic        o_status,
    output logic        o_image_done,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [tgapsd_pkg::CFG_W-1:0] i_cfg_data
);
    import tgapsd_pkg::*;

    t_cfg r_cfg;
    t_job front_job, back_job;
    t_res back_res, out_res;
    logic front_push, back_pop, mid_empty, res_full, res_push, accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_kind    <= 2'd2;
            r_cfg.pixel_bytes   <= 3'd4;
            r_cfg.alpha_used    <= 1'b0;
            r_cfg.rle_on        <= 1'b0;
            r_cfg.pixel_total   <= TOTAL_W'(1);
            r_cfg.palette_bits  <= 6'd24;
            r_cfg.palette_first <= 16'd0;
            r_cfg.palette_count <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_IMAGE_KIND:    r_cfg.image_kind    <= i_cfg_data[1:0];
                REG_PIXEL_BYTES:   r_cfg.pixel_bytes   <= i_cfg_data[2:0];
                REG_ALPHA_USED:    r_cfg.alpha_used    <= i_cfg_data[0];
                REG_RLE_ON:        r_cfg.rle_on        <= i_cfg_data[0];
                REG_PIXEL_TOTAL:   r_cfg.pixel_total   <= i_cfg_data[TOTAL_W-1:0];
                REG_PALETTE_BITS:  r_cfg.palette_bits  <= i_cfg_data[5:0];
                REG_PALETTE_FIRST: r_cfg.palette_first <= i_cfg_data[15:0];
                REG_PALETTE_COUNT: r_cfg.palette_count <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign accept = push && !full;

    tgapsd_front #(
        .PALETTE_DEPTH(PALETTE_DEPTH),
        .MAX_PIXELS   (MAX_PIXELS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_accept   (accept),
        .i_func     (i_func),
        .i_data_byte(i_data_byte),
        .o_job_push (front_push),
        .o_job      (front_job)
    );

    tgapsd_fifo #(
        .DEPTH (4),
        .t_item(t_job)
    ) u_mid_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (front_push),
        .i_item (front_job),
        .o_full (full),
        .i_pop  (back_pop),
        .o_item (back_job),
        .o_empty(mid_empty)
    );

    tgapsd_back #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_job_empty(mid_empty),
        .i_job      (back_job),
        .o_job_pop  (back_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (back_res)
    );

    tgapsd_fifo #(
        .DEPTH (4),
        .t_item(t_res)
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_item (back_res),
        .o_full (res_full),
        .i_pop  (pop),
        .o_item (out_res),
        .o_empty(empty)
    );

    assign o_argb       = out_res.argb;
    assign o_run_length = out_res.run;
    assign o_status     = out_res.status;
    assign o_image_done = out_res.done;

endmodule
